@@ rtl/tmr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timer package
// Word types, register numbers and widths shared by the timer modules.
// ----------------------------------------------------------------------------
package tmr_pkg;

    // Fixed widths of the word fields.
    localparam int DATA_W      = 32;
    localparam int TIME_W      = 64;
    localparam int IRQ_W       = 4;
    localparam int MODE_W      = 2;
    localparam int REG_W       = 5;

    // Default and largest number of compare alarms.
    localparam int NUM_ALARMS_DEF = 4;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // Register numbers.
    localparam logic [REG_W-1:0] REG_TIMEHW   = 5'd0;
    localparam logic [REG_W-1:0] REG_TIMELW   = 5'd1;
    localparam logic [REG_W-1:0] REG_TIMEHR   = 5'd2;
    localparam logic [REG_W-1:0] REG_TIMELR   = 5'd3;
    localparam logic [REG_W-1:0] REG_ALARM0   = 5'd4;
    localparam logic [REG_W-1:0] REG_ARMED    = 5'd8;
    localparam logic [REG_W-1:0] REG_RAWH     = 5'd9;
    localparam logic [REG_W-1:0] REG_RAWL     = 5'd10;
    localparam logic [REG_W-1:0] REG_DBGPAUSE = 5'd11;
    localparam logic [REG_W-1:0] REG_PAUSE    = 5'd12;
    localparam logic [REG_W-1:0] REG_INTR     = 5'd13;
    localparam logic [REG_W-1:0] REG_INTE     = 5'd14;
    localparam logic [REG_W-1:0] REG_INTF     = 5'd15;
    localparam logic [REG_W-1:0] REG_INTS     = 5'd16;

    // Input word: a tick, a register read or a register write.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [REG_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] tick_count;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_pulse;
        logic [IRQ_W-1:0]  irq_level;
    } t_out_word;

endpackage
`default_nettype wire

@@ rtl/timer_with_compare_alarms.sv @@
// A word taken is held in the input register, then its result in the output register.
// Throughput: one word per cycle while the output is not stalled; the 64-bit time
// add and the per-alarm compares sit in one stage between the input and output registers.
// Reset: synchronous, active low; all timer state and the valid flags of both
// word registers are cleared directly, with no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// Timer with compare alarms
// A 64-bit microsecond timer with compare alarms behind a register file.
// ----------------------------------------------------------------------------
module timer_with_compare_alarms #(
    parameter int NUM_ALARMS = tmr_pkg::NUM_ALARMS_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output                     logic o_in_stall,
    input  wire tmr_pkg::t_in_word  i_in_word,
    output                     logic o_out_valid,
    input  wire                logic i_out_stall,
    output      tmr_pkg::t_out_word o_out_word
);

    localparam logic [tmr_pkg::IRQ_W-1:0] ALARM_MASK =
        tmr_pkg::IRQ_W'((1 << NUM_ALARMS) - 1);

    logic               r_in_valid;
    tmr_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    tmr_pkg::t_out_word r_out_word;
    tmr_pkg::t_out_word w_core_word;
    logic               w_out_load;
    logic               w_fire;
    logic               w_in_take;

    // Pipeline control: the output register frees the input register.
    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_load;
    assign o_in_stall = r_in_valid && !w_out_load;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // State and result logic.
    tmr_core #(
        .NUM_ALARMS(NUM_ALARMS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_word  (r_in_word),
        .o_word  (w_core_word)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_word <= w_core_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // A pulse comes from a tick or a mask write, never from a read.
    a_pulse_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.irq_pulse != '0) |-> o_out_word.read_data == '0)
        else $error("irq pulse reported together with read data");

    // No interrupt line beyond the configured alarms is ever active.
    a_level_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.irq_level | o_out_word.irq_pulse) & ~ALARM_MASK) == '0)
        else $error("irq line active beyond the configured alarms");

    // The input side stalls only while a word waits in the input register.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid && i_out_stall)
        else $error("input stalled without a blocked word");

    // A word that moves on leaves a valid result in the output register.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("word fired without a result");
`endif

endmodule
`default_nettype wire

@@ rtl/tmr_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Timer core
// Holds the time, alarm and interrupt state and works out one word's result.
// ----------------------------------------------------------------------------
module tmr_core #(
    parameter int NUM_ALARMS = tmr_pkg::NUM_ALARMS_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_fire,
    input  wire tmr_pkg::t_in_word  i_word,
    output      tmr_pkg::t_out_word o_word
);

    localparam logic [tmr_pkg::IRQ_W-1:0] ALARM_MASK =
        tmr_pkg::IRQ_W'((1 << NUM_ALARMS) - 1);

    logic [tmr_pkg::TIME_W-1:0] r_time,    n_time;
    logic [tmr_pkg::DATA_W-1:0] r_target [NUM_ALARMS];
    logic [tmr_pkg::DATA_W-1:0] n_target [NUM_ALARMS];
    logic [tmr_pkg::IRQ_W-1:0]  r_armed,   n_armed;
    logic [tmr_pkg::IRQ_W-1:0]  r_raw,     n_raw;
    logic [tmr_pkg::IRQ_W-1:0]  r_enable,  n_enable;
    logic [tmr_pkg::IRQ_W-1:0]  r_force,   n_force;
    logic                       r_paused,  n_paused;
    logic [tmr_pkg::DATA_W-1:0] r_latched, n_latched;

    logic [tmr_pkg::DATA_W-1:0] w_rdata;
    logic [tmr_pkg::IRQ_W-1:0]  w_pulse;
    logic [tmr_pkg::IRQ_W-1:0]  w_level;
    logic [tmr_pkg::DATA_W-1:0] w_diff [NUM_ALARMS];

    // Next state and result of the word in the input register.
    always_comb begin
        n_time    = r_time;
        n_target  = r_target;
        n_armed   = r_armed;
        n_raw     = r_raw;
        n_enable  = r_enable;
        n_force   = r_force;
        n_paused  = r_paused;
        n_latched = r_latched;
        w_rdata   = '0;
        w_pulse   = '0;
        for (int k = 0; k < NUM_ALARMS; k++) begin
            w_diff[k] = '0;
        end

        case (i_word.mode)
            tmr_pkg::MODE_TICK: begin
                // A running tick advances time, then fires the armed alarms it has reached.
                if (!r_paused) begin
                    n_time = r_time + {32'd0, i_word.tick_count};
                    for (int k = 0; k < NUM_ALARMS; k++) begin
                        w_diff[k] = n_time[tmr_pkg::DATA_W-1:0] - r_target[k];
                        if (r_armed[k] && !w_diff[k][tmr_pkg::DATA_W-1]) begin
                            n_raw[k]   = 1'b1;
                            n_armed[k] = 1'b0;
                            w_pulse[k] = 1'b1;
                        end
                    end
                end
            end
            tmr_pkg::MODE_READ: begin
                for (int k = 0; k < NUM_ALARMS; k++) begin
                    if (i_word.reg_index == tmr_pkg::REG_W'(tmr_pkg::REG_ALARM0 + k)) begin
                        w_rdata = r_target[k];
                    end
                end
                case (i_word.reg_index)
                    tmr_pkg::REG_TIMEHR: w_rdata = r_latched;
                    tmr_pkg::REG_TIMELR: begin
                        n_latched = r_time[tmr_pkg::TIME_W-1:tmr_pkg::DATA_W];
                        w_rdata   = r_time[tmr_pkg::DATA_W-1:0];
                    end
                    tmr_pkg::REG_ARMED: w_rdata = {28'd0, r_armed};
                    tmr_pkg::REG_RAWH:  w_rdata = r_time[tmr_pkg::TIME_W-1:tmr_pkg::DATA_W];
                    tmr_pkg::REG_RAWL:  w_rdata = r_time[tmr_pkg::DATA_W-1:0];
                    tmr_pkg::REG_PAUSE: w_rdata = {31'd0, r_paused};
                    tmr_pkg::REG_INTR:  w_rdata = {28'd0, r_raw};
                    tmr_pkg::REG_INTE:  w_rdata = {28'd0, r_enable};
                    tmr_pkg::REG_INTF:  w_rdata = {28'd0, r_force};
                    tmr_pkg::REG_INTS:  w_rdata = {28'd0, (r_raw | r_force) & r_enable};
                    default: begin
                    end
                endcase
            end
            tmr_pkg::MODE_WRITE: begin
                // Writing an alarm stores its target and arms it.
                for (int k = 0; k < NUM_ALARMS; k++) begin
                    if (i_word.reg_index == tmr_pkg::REG_W'(tmr_pkg::REG_ALARM0 + k)) begin
                        n_target[k] = i_word.write_data;
                        n_armed[k]  = 1'b1;
                    end
                end
                case (i_word.reg_index)
                    tmr_pkg::REG_TIMEHW: n_time[tmr_pkg::TIME_W-1:tmr_pkg::DATA_W] =
                        i_word.write_data;
                    tmr_pkg::REG_TIMELW: n_time[tmr_pkg::DATA_W-1:0] = i_word.write_data;
                    tmr_pkg::REG_ARMED:  n_armed = r_armed & ~i_word.write_data[3:0] &
                        ALARM_MASK;
                    tmr_pkg::REG_PAUSE:  n_paused = i_word.write_data[0];
                    tmr_pkg::REG_INTR:   n_raw = r_raw & ~i_word.write_data[3:0] & ALARM_MASK;
                    tmr_pkg::REG_INTE: begin
                        n_enable = i_word.write_data[3:0] & ALARM_MASK;
                        w_pulse  = (r_raw | r_force) & n_enable;
                    end
                    tmr_pkg::REG_INTF: begin
                        n_force = i_word.write_data[3:0] & ALARM_MASK;
                        w_pulse = (r_raw | n_force) & r_enable;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        w_level = (n_raw | n_force) & n_enable;
    end

    // Result word handed to the output register.
    assign o_word.read_data = w_rdata;
    assign o_word.irq_pulse = w_pulse;
    assign o_word.irq_level = w_level;

    // State registers, updated only when a word moves to the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_armed   <= '0;
            r_raw     <= '0;
            r_enable  <= '0;
            r_force   <= '0;
            r_paused  <= 1'b0;
            r_latched <= '0;
            for (int k = 0; k < NUM_ALARMS; k++) begin
                r_target[k] <= '0;
            end
        end else if (i_fire) begin
            r_time    <= n_time;
            r_armed   <= n_armed;
            r_raw     <= n_raw;
            r_enable  <= n_enable;
            r_force   <= n_force;
            r_paused  <= n_paused;
            r_latched <= n_latched;
            r_target  <= n_target;
        end
    end

endmodule
`default_nettype wire
